// ===== design/led_blink_pattern_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// LED blink pattern generator assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_GENERATOR_CORE_MACROS_SVH
`define LED_BLINK_PATTERN_GENERATOR_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define LBPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define LBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lbpg_pkg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern generator package
// Mode and register codes, threshold set type and the helper functions.
// ----------------------------------------------------------------------------
package lbpg_pkg;

    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int HALF_W   = 15;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_ON         = 3'd1,
        MODE_BLINK      = 3'd2,
        MODE_DOUBLE     = 3'd3,
        MODE_TRIPLE     = 3'd4,
        MODE_BLINK_ALT  = 3'd5,
        MODE_DOUBLE_ALT = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE_FIRST    = 2'd0,
        CFG_MODE_SECOND   = 2'd1,
        CFG_PERIOD_FIRST  = 2'd2,
        CFG_PERIOD_SECOND = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [PERIOD_W-1:0] full;
        logic [HALF_W-1:0]   half;
        logic [HALF_W-1:0]   third;
        logic [HALF_W-1:0]   two_third;
        logic [HALF_W-1:0]   fifth;
        logic [HALF_W-1:0]   two_fifth;
        logic [HALF_W-1:0]   three_fifth;
        logic [HALF_W-1:0]   four_fifth;
    } t_thr;

    // Exact for every 16-bit value: 43691 * 3 = 2^17 + 1.
    function automatic logic [HALF_W-1:0] div3(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd43691;
        return p[31:17];
    endfunction

    // Exact for every 17-bit value: 104858 * 5 = 2^19 + 2.
    function automatic logic [HALF_W-1:0] div5(input logic [16:0] x);
        logic [33:0] p;
        p = 34'(x) * 34'd104858;
        return p[33:19];
    endfunction

    function automatic t_thr thr_calc(input logic [PERIOD_W-1:0] period);
        t_thr        t;
        logic [HALF_W-1:0] h;
        h             = period[PERIOD_W-1:1];
        t.half        = h;
        t.full        = {h, 1'b0};
        t.third       = div3({1'b0, h});
        t.two_third   = div3({h, 1'b0});
        t.fifth       = div5({2'b00, h});
        t.two_fifth   = div5({1'b0, h, 1'b0});
        t.three_fifth = div5(17'({h, 1'b0}) + 17'(h));
        t.four_fifth  = div5({h, 2'b00});
        return t;
    endfunction

    function automatic logic past(
        input logic [TIME_W-1:0]   t,
        input logic [TIME_W-1:0]   base,
        input logic [PERIOD_W-1:0] off
    );
        logic [TIME_W-1:0] s;
        s = base + TIME_W'(off);
        return t > s;
    endfunction

endpackage

// ===== design/lbpg_cfg.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern generator configuration registers
// Holds both modes and the threshold sets derived from each period.
// ----------------------------------------------------------------------------
module lbpg_cfg
    import lbpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output t_mode       o_mode_first,
    output t_mode       o_mode_second,
    output t_thr        o_thr_first,
    output t_thr        o_thr_second
);

    t_mode r_mode_first;
    t_mode r_mode_second;
    t_thr  r_thr_first;
    t_thr  r_thr_second;
    t_thr  n_thr;

    assign n_thr = thr_calc(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_first  <= MODE_OFF;
            r_mode_second <= MODE_OFF;
            r_thr_first   <= thr_calc(PERIOD_RESET);
            r_thr_second  <= thr_calc(PERIOD_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MODE_FIRST:    r_mode_first  <= t_mode'(i_cfg_wdata[2:0]);
                CFG_MODE_SECOND:   r_mode_second <= t_mode'(i_cfg_wdata[2:0]);
                CFG_PERIOD_FIRST:  r_thr_first   <= n_thr;
                CFG_PERIOD_SECOND: r_thr_second  <= n_thr;
                default:           r_thr_first   <= r_thr_first;
            endcase
        end
    end

    assign o_mode_first  = r_mode_first;
    assign o_mode_second = r_mode_second;
    assign o_thr_first   = r_thr_first;
    assign o_thr_second  = r_thr_second;

endmodule

// ===== design/lbpg_led.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern generator LED channel
// Restart time and level of one LED, updated once per processed timestamp.
// ----------------------------------------------------------------------------
module lbpg_led
    import lbpg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_time,
    input  t_mode             i_mode,
    input  t_thr              i_thr,
    output logic              o_level
);

    logic              r_level;
    logic              n_level;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] n_last;

    always_comb begin
        n_level = r_level;
        n_last  = r_last;
        unique case (i_mode) inside
            MODE_OFF: begin
                n_level = 1'b0;
            end
            MODE_ON: begin
                n_level = 1'b1;
            end
            MODE_BLINK: begin
                if (past(i_time, r_last, PERIOD_W'(i_thr.half))) begin
                    n_level = ~r_level;
                    n_last  = i_time;
                end
            end
            MODE_DOUBLE, MODE_TRIPLE, MODE_BLINK_ALT, MODE_DOUBLE_ALT: begin
                if (past(i_time, r_last, i_thr.full)) begin
                    n_level = 1'b1;
                    n_last  = i_time;
                end else if (i_mode == MODE_DOUBLE) begin
                    if (past(i_time, r_last, PERIOD_W'(i_thr.half))) begin
                        n_level = 1'b0;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.two_third))) begin
                        n_level = 1'b1;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.third))) begin
                        n_level = 1'b0;
                    end
                end else if (i_mode == MODE_TRIPLE) begin
                    if (past(i_time, r_last, PERIOD_W'(i_thr.half))) begin
                        n_level = 1'b0;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.four_fifth))) begin
                        n_level = 1'b1;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.three_fifth))) begin
                        n_level = 1'b0;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.two_fifth))) begin
                        n_level = 1'b1;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.fifth))) begin
                        n_level = 1'b0;
                    end
                end else if (i_mode == MODE_BLINK_ALT) begin
                    if (past(i_time, r_last, PERIOD_W'(i_thr.fifth))) begin
                        n_level = 1'b0;
                    end
                end else begin
                    if (past(i_time, r_last, PERIOD_W'(i_thr.three_fifth))) begin
                        n_level = 1'b0;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.two_fifth))) begin
                        n_level = 1'b1;
                    end else if (past(i_time, r_last, PERIOD_W'(i_thr.fifth))) begin
                        n_level = 1'b0;
                    end
                end
            end
            default: begin
                n_level = r_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_last  <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_last  <= n_last;
        end
    end

    assign o_level = r_level;

endmodule

// ===== design/led_blink_pattern_generator_core.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern generator core
// An accepted timestamp is held in the input register and then processed
// into the LED state registers, which double as the result register.
// One timestamp is accepted per cycle while the result side does not stall.
// Synchronous active-low reset turns both LEDs off, clears the restart
// times, selects mode off and loads a period of 1000 ms for both LEDs.
// ----------------------------------------------------------------------------
`include "led_blink_pattern_generator_core_macros.svh"

module led_blink_pattern_generator_core
    import lbpg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] time_ms
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] led_first_on, [1] led_second_on
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    logic              r_in_valid;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    logic              adv;
    t_mode             mode_first;
    t_mode             mode_second;
    t_thr              thr_first;
    t_thr              thr_second;
    logic              level_first;
    logic              level_second;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_time <= i_s_axis_tdata;
        end
    end

    lbpg_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mode_first  (mode_first),
        .o_mode_second (mode_second),
        .o_thr_first   (thr_first),
        .o_thr_second  (thr_second)
    );

    lbpg_led u_led_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_time  (r_in_time),
        .i_mode  (mode_first),
        .i_thr   (thr_first),
        .o_level (level_first)
    );

    lbpg_led u_led_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_time  (r_in_time),
        .i_mode  (mode_second),
        .i_thr   (thr_second),
        .o_level (level_second)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b000000, level_second, level_first};

    `LBPG_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid,
        "Pending timestamp was dropped while the result side stalled.")
    `LBPG_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, adv, o_m_axis_tvalid,
        "Processed timestamp produced no result.")
    `LBPG_ASSERT_NEXT(a_off_dark, i_clk, i_rst_n, adv && mode_first == MODE_OFF,
        !o_m_axis_tdata[0], "First LED lit after an update in mode off.")
    `LBPG_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready,
        "Input stalled although no result is waiting.")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// LED blink pattern generator core testbench
// Streams millisecond timestamps into the core and compares both LED levels
// of every result with a behavioural prediction. Settings are rewritten while
// the core is idle, between runs of ticks. Both stream sides idle at random,
// and the receiver holds off once for a long stretch so that the core stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbpg_pkg::*;

    localparam int          CLK_HALF      = 5;
    localparam int          TICK_TARGET   = 450;
    localparam int          CALM_TAIL     = 60;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          HOLD_EXTRA    = 40;
    localparam int          CYCLE_LIMIT   = 300000;
    localparam logic [2:0]  MODE_RESERVED = 3'd7;

    class led_scoreboard;
        logic [2:0]  mode_q[2];
        logic [15:0] period_q[2];
        logic [31:0] restart_q[2];
        logic        level_q[2];
        logic [1:0]  levels_due[$];
        int          errors;

        function new();
            for (int k = 0; k < 2; k++) begin
                mode_q[k]    = MODE_OFF;
                period_q[k]  = PERIOD_RESET;
                restart_q[k] = '0;
                level_q[k]   = 1'b0;
            end
            errors = 0;
        endfunction

        function void report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                CFG_MODE_FIRST:    mode_q[0]   = value[2:0];
                CFG_MODE_SECOND:   mode_q[1]   = value[2:0];
                CFG_PERIOD_FIRST:  period_q[0] = value;
                CFG_PERIOD_SECOND: period_q[1] = value;
                default: ;
            endcase
        endfunction

        // Unsigned comparison against a sum that wraps on 32 bits.
        function bit beyond(logic [31:0] t, logic [31:0] base, logic [31:0] off);
            logic [31:0] s;
            s = base + off;
            return t > s;
        endfunction

        function void advance_led(int k, logic [31:0] t);
            logic [31:0] h;
            logic [31:0] b;
            h = {17'd0, period_q[k][15:1]};
            b = restart_q[k];
            case (mode_q[k])
                MODE_OFF: level_q[k] = 1'b0;
                MODE_ON:  level_q[k] = 1'b1;
                MODE_BLINK: begin
                    if (beyond(t, b, h)) begin
                        level_q[k]   = ~level_q[k];
                        restart_q[k] = t;
                    end
                end
                MODE_DOUBLE, MODE_TRIPLE, MODE_BLINK_ALT, MODE_DOUBLE_ALT: begin
                    if (beyond(t, b, 2 * h)) begin
                        level_q[k]   = 1'b1;
                        restart_q[k] = t;
                    end else if (mode_q[k] == MODE_DOUBLE) begin
                        if (beyond(t, b, h))                level_q[k] = 1'b0;
                        else if (beyond(t, b, (2 * h) / 3)) level_q[k] = 1'b1;
                        else if (beyond(t, b, h / 3))       level_q[k] = 1'b0;
                    end else if (mode_q[k] == MODE_TRIPLE) begin
                        if (beyond(t, b, h))                level_q[k] = 1'b0;
                        else if (beyond(t, b, (4 * h) / 5)) level_q[k] = 1'b1;
                        else if (beyond(t, b, (3 * h) / 5)) level_q[k] = 1'b0;
                        else if (beyond(t, b, (2 * h) / 5)) level_q[k] = 1'b1;
                        else if (beyond(t, b, h / 5))       level_q[k] = 1'b0;
                    end else if (mode_q[k] == MODE_BLINK_ALT) begin
                        if (beyond(t, b, h / 5))            level_q[k] = 1'b0;
                    end else begin
                        if (beyond(t, b, (3 * h) / 5))      level_q[k] = 1'b0;
                        else if (beyond(t, b, (2 * h) / 5)) level_q[k] = 1'b1;
                        else if (beyond(t, b, h / 5))       level_q[k] = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_tick(logic [31:0] t);
            advance_led(0, t);
            advance_led(1, t);
            levels_due.push_back({level_q[1], level_q[0]});
        endfunction

        function void check_levels(logic [7:0] data);
            logic [1:0] want;
            if (levels_due.size() == 0) begin
                report($sformatf("unexpected result 0x%02h", data));
                return;
            end
            want = levels_due.pop_front();
            if (data[0] !== want[0]) begin
                report($sformatf("led_first_on %b, predicted %b", data[0], want[0]));
            end
            if (data[1] !== want[1]) begin
                report($sformatf("led_second_on %b, predicted %b", data[1], want[1]));
            end
            if (data[7:2] !== 6'd0) begin
                report($sformatf("padding bits 0x%02h are not zero", data[7:2]));
            end
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        function void drain_check();
            if (levels_due.size() != 0) begin
                report($sformatf("%0d results never arrived", levels_due.size()));
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [31:0] time_ms
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // [0] led_first_on, [1] led_second_on
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = '0;
    logic [15:0] i_cfg_wdata     = '0;

    led_scoreboard sb = new();
    int            ticks_sent  = 0;
    int            cycle_count = 0;
    bit            idle_on     = 1'b1;
    bit            hold_request = 1'b0;

    led_blink_pattern_generator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_tick(i_s_axis_tdata);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_levels(o_m_axis_tdata);
        end
    end

    initial begin : sink
        int gap;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_axis_tready <= 1'b0;
                gap = HOLD_CYCLES;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                gap = $urandom_range(1, 17);
            end else begin
                i_m_axis_tready <= 1'b1;
                gap = $urandom_range(1, 12);
            end
            repeat (gap) @(posedge i_clk);
        end
    end

    task automatic send_tick(input logic [31:0] t);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= t;
        do @(posedge i_clk); while (!o_s_axis_tready);
        ticks_sent++;
    endtask

    task automatic drive_ticks(input logic [31:0] start, input int count,
                               input logic [31:0] step);
        logic [31:0] t;
        t = start;
        for (int n = 0; n < count; n++) begin
            send_tick(t);
            t = t + step;
        end
    endtask

    task automatic load_settings(input logic [2:0] m0, input logic [2:0] m1,
                                 input logic [15:0] p0, input logic [15:0] p1);
        logic [15:0] vals[4];
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        vals[0] = {13'd0, m0};
        vals[1] = {13'd0, m1};
        vals[2] = p0;
        vals[3] = p1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= t_cfg_idx'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.write_reg(t_cfg_idx'(i), vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [2:0] pick_mode();
        case ($urandom_range(0, 15))
            0:       return MODE_OFF;
            1:       return MODE_ON;
            2:       return MODE_RESERVED;
            default: return 3'($urandom_range(MODE_BLINK, MODE_DOUBLE_ALT));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        logic [15:0] edges[4];
        edges = '{16'd0, 16'd1, 16'd65534, 16'd65535};
        case ($urandom_range(0, 9))
            0:       return edges[$urandom_range(0, 3)];
            1:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2, 120));
        endcase
    endfunction

    initial begin : stimulus
        logic [2:0]  m0;
        logic [2:0]  m1;
        logic [15:0] p0;
        logic [15:0] p1;
        logic [31:0] clock_ms;
        logic [31:0] scale;
        int          count;
        bit          held;
        clock_ms = '0;
        held     = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, then every mode with odd and extreme periods.
        drive_ticks(32'd0, 1, 32'd0);
        drive_ticks(32'hFFFF_FFFF, 1, 32'd0);
        load_settings(MODE_ON, MODE_BLINK, 16'd65535, 16'd1);
        drive_ticks(32'd5, 4, 32'd1);
        load_settings(MODE_DOUBLE, MODE_TRIPLE, 16'd30, 16'd31);
        drive_ticks(32'd100, 9, 32'd2);
        // The restart sums wrap past the top of the time range here.
        load_settings(MODE_BLINK_ALT, MODE_DOUBLE_ALT, 16'd30, 16'd30);
        drive_ticks(32'hFFFF_FFF8, 5, 32'd3);
        load_settings(MODE_RESERVED, MODE_OFF, 16'd0, 16'd0);
        drive_ticks(32'h8000_0000, 2, 32'h8000_0001);

        while (ticks_sent < TICK_TARGET) begin
            m0 = pick_mode();
            m1 = pick_mode();
            p0 = pick_period();
            p1 = pick_period();
            load_settings(m0, m1, p0, p1);
            case ($urandom_range(0, 4))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                default: ;
            endcase
            count = $urandom_range(10, 40);
            // The run that carries the long hold is made long enough that the
            // sender is still offering transactions while the receiver waits.
            if (!held && ticks_sent > 150) begin
                held = 1'b1;
                hold_request = 1'b1;
                count = count + HOLD_EXTRA;
            end
            for (int n = 0; n < count; n++) begin
                if (ticks_sent >= TICK_TARGET - CALM_TAIL) begin
                    idle_on = 1'b0;
                end
                scale = $urandom_range(0, 1) ? {17'd0, p0[15:1]} : {17'd0, p1[15:1]};
                case ($urandom_range(0, 19))
                    0:       clock_ms = $urandom();
                    1:       clock_ms = clock_ms - $urandom_range(0, scale);
                    default: clock_ms = clock_ms + $urandom_range(0, scale / 3 + 1);
                endcase
                send_tick(clock_ms);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.drain_check();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/lbpg_pkg.sv
design/lbpg_cfg.sv
design/lbpg_led.sv
design/led_blink_pattern_generator_core.sv
tb/sv/tb.sv
